[rtl/adr_pkg.sv]
// Shared types, widths, register codes and the duty function for the
// averaging converter front end. No dependencies.
package adr_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 16;
  localparam int TALLY_W  = 7;
  localparam int CHAN_W   = 4;
  localparam int SLOPE_W  = 8;
  localparam int PROD_W   = SUM_W + SLOPE_W;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_ACC_COUNT  = 3'd0;
  localparam logic [2:0] REG_CHAN_TABLE = 3'd1;
  localparam logic [2:0] REG_VOLT_LOW   = 3'd2;
  localparam logic [2:0] REG_VOLT_HIGH  = 3'd3;
  localparam logic [2:0] REG_PWR_FULL   = 3'd4;
  localparam logic [2:0] REG_PWR_SLOPE  = 3'd5;
  localparam logic [2:0] REG_LED_FULL   = 3'd6;
  localparam logic [2:0] REG_LED_SLOPE  = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [TALLY_W-1:0] ACC_COUNT_RST  = 7'd16;
  localparam logic [7:0]         CHAN_TABLE_RST = 8'h10;
  localparam logic [SUM_W-1:0]   VOLT_LOW_RST   = 16'h0000;
  localparam logic [SUM_W-1:0]   VOLT_HIGH_RST  = 16'hFFFF;

  typedef struct packed {
    logic [TALLY_W-1:0] accumulate_count;
    logic [7:0]         channel_table;
    logic [SUM_W-1:0]   voltage_low_limit;
    logic [SUM_W-1:0]   voltage_high_limit;
    logic [SUM_W-1:0]   power_duty_full;
    logic [SLOPE_W-1:0] power_slope;
    logic [SUM_W-1:0]   led_duty_full;
    logic [SLOPE_W-1:0] led_slope;
  } cfg_t;

  // One published sum on its way to the duty stage.
  typedef struct packed {
    logic              finished_slot;
    logic [SUM_W-1:0]  channel_sum;
    logic [CHAN_W-1:0] next_channel;
    logic [SUM_W-1:0]  volt;
  } pub_t;

  // Full below the low limit, zero at or above the high limit, otherwise
  // the distance to the high limit times the slope, saturated.
  function automatic logic [SUM_W-1:0] duty_calc(
    input logic [SUM_W-1:0]   v,
    input logic [SUM_W-1:0]   lo,
    input logic [SUM_W-1:0]   hi,
    input logic [SUM_W-1:0]   full,
    input logic [SLOPE_W-1:0] slope
  );
    logic [SUM_W-1:0]  diff;
    logic [PROD_W-1:0] prod;
    diff = hi - v;
    prod = diff * slope;
    if (v < lo) begin
      return full;
    end else if (v >= hi) begin
      return '0;
    end else if (|prod[PROD_W-1:SUM_W]) begin
      return '1;
    end else begin
      return prod[SUM_W-1:0];
    end
  endfunction

endpackage

[rtl/adr_if.sv]
// Valid/ready stream interfaces for the sample and result channels.
// Depends on adr_pkg for the field widths.
interface adr_in_if;
  logic                          valid;
  logic                          ready;
  logic [adr_pkg::SAMPLE_W-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface adr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        finished_slot;
  logic [adr_pkg::SUM_W-1:0]   channel_sum;
  logic [adr_pkg::CHAN_W-1:0]  next_channel;
  logic [adr_pkg::SUM_W-1:0]   power_duty;
  logic [adr_pkg::SUM_W-1:0]   led_duty;
  modport source (output valid, output finished_slot, output channel_sum,
                  output next_channel, output power_duty, output led_duty,
                  input ready);
  modport sink   (input valid, input finished_slot, input channel_sum,
                  input next_channel, input power_duty, input led_duty,
                  output ready);
endinterface

[rtl/adr_regs.sv]
// APB-style configuration register file of the averaging front end.
// Depends on adr_pkg for the register codes and the cfg_t layout.
module adr_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [adr_pkg::ADDR_W-1:0]  paddr,
  input  logic [adr_pkg::DATA_W-1:0]  pwdata,
  output logic [adr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output adr_pkg::cfg_t               cfg
);

  adr_pkg::cfg_t cfg_r;
  adr_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        adr_pkg::REG_ACC_COUNT:  cfg_nxt.accumulate_count   = pwdata[adr_pkg::TALLY_W-1:0];
        adr_pkg::REG_CHAN_TABLE: cfg_nxt.channel_table      = pwdata[7:0];
        adr_pkg::REG_VOLT_LOW:   cfg_nxt.voltage_low_limit  = pwdata[adr_pkg::SUM_W-1:0];
        adr_pkg::REG_VOLT_HIGH:  cfg_nxt.voltage_high_limit = pwdata[adr_pkg::SUM_W-1:0];
        adr_pkg::REG_PWR_FULL:   cfg_nxt.power_duty_full    = pwdata[adr_pkg::SUM_W-1:0];
        adr_pkg::REG_PWR_SLOPE:  cfg_nxt.power_slope        = pwdata[adr_pkg::SLOPE_W-1:0];
        adr_pkg::REG_LED_FULL:   cfg_nxt.led_duty_full      = pwdata[adr_pkg::SUM_W-1:0];
        adr_pkg::REG_LED_SLOPE:  cfg_nxt.led_slope          = pwdata[adr_pkg::SLOPE_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accumulate_count   <= adr_pkg::ACC_COUNT_RST;
      cfg_r.channel_table      <= adr_pkg::CHAN_TABLE_RST;
      cfg_r.voltage_low_limit  <= adr_pkg::VOLT_LOW_RST;
      cfg_r.voltage_high_limit <= adr_pkg::VOLT_HIGH_RST;
      cfg_r.power_duty_full    <= '0;
      cfg_r.power_slope        <= '0;
      cfg_r.led_duty_full      <= '0;
      cfg_r.led_slope          <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      adr_pkg::REG_ACC_COUNT:  prdata = {25'd0, cfg_r.accumulate_count};
      adr_pkg::REG_CHAN_TABLE: prdata = {24'd0, cfg_r.channel_table};
      adr_pkg::REG_VOLT_LOW:   prdata = {16'd0, cfg_r.voltage_low_limit};
      adr_pkg::REG_VOLT_HIGH:  prdata = {16'd0, cfg_r.voltage_high_limit};
      adr_pkg::REG_PWR_FULL:   prdata = {16'd0, cfg_r.power_duty_full};
      adr_pkg::REG_PWR_SLOPE:  prdata = {24'd0, cfg_r.power_slope};
      adr_pkg::REG_LED_FULL:   prdata = {16'd0, cfg_r.led_duty_full};
      adr_pkg::REG_LED_SLOPE:  prdata = {24'd0, cfg_r.led_slope};
      default:                 prdata = '0;
    endcase
  end

endmodule

[rtl/adr_accum.sv]
// Sample input register, per-slot summing and round-robin slot stepping.
// Depends on adr_pkg for cfg_t, pub_t and the field widths.
module adr_accum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [adr_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         in_ready,
  input  adr_pkg::cfg_t                cfg,
  output logic                         pub_valid,
  output adr_pkg::pub_t                pub,
  input  logic                         pub_take
);

  logic                         smp_v_r, smp_v_nxt;
  logic [adr_pkg::SAMPLE_W-1:0] smp_r;
  logic [adr_pkg::TALLY_W-1:0]  tally_r, tally_nxt;
  logic [adr_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic                         slot_r, slot_nxt;
  logic [adr_pkg::SUM_W-1:0]    volt_r, volt_nxt;
  logic                         pub_v_r, pub_v_nxt;
  adr_pkg::pub_t                pub_r;
  adr_pkg::pub_t                pub_nxt;

  logic                         fire;
  logic                         in_take;
  logic [adr_pkg::SUM_W-1:0]    sum_add;
  logic [adr_pkg::TALLY_W-1:0]  tally_inc;
  logic                         done;

  assign fire      = smp_v_r & (~pub_v_r | pub_take);
  assign in_ready  = ~smp_v_r | fire;
  assign in_take   = in_valid & in_ready;
  assign sum_add   = sum_r + {{(adr_pkg::SUM_W-adr_pkg::SAMPLE_W){1'b0}}, smp_r};
  assign tally_inc = tally_r + 1'b1;
  // A count of zero, or one lowered below the tally, publishes at once.
  assign done      = (tally_inc >= cfg.accumulate_count);

  always_comb begin
    smp_v_nxt = in_take | (smp_v_r & ~fire);
    tally_nxt = tally_r;
    sum_nxt   = sum_r;
    slot_nxt  = slot_r;
    volt_nxt  = volt_r;
    pub_nxt   = pub_r;
    pub_v_nxt = pub_take ? 1'b0 : pub_v_r;
    if (fire) begin
      if (done) begin
        tally_nxt             = '0;
        sum_nxt               = '0;
        slot_nxt              = ~slot_r;
        pub_v_nxt             = 1'b1;
        pub_nxt.finished_slot = slot_r;
        pub_nxt.channel_sum   = sum_add;
        pub_nxt.next_channel  = slot_r ? cfg.channel_table[3:0]
                                       : cfg.channel_table[7:4];
        // Duties follow slot 0, the input voltage, just updated or not.
        if (!slot_r) begin
          volt_nxt     = sum_add;
          pub_nxt.volt = sum_add;
        end else begin
          pub_nxt.volt = volt_r;
        end
      end else begin
        tally_nxt = tally_inc;
        sum_nxt   = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_v_r <= 1'b0;
      tally_r <= '0;
      sum_r   <= '0;
      slot_r  <= 1'b0;
      volt_r  <= '0;
      pub_v_r <= 1'b0;
    end else begin
      smp_v_r <= smp_v_nxt;
      tally_r <= tally_nxt;
      sum_r   <= sum_nxt;
      slot_r  <= slot_nxt;
      volt_r  <= volt_nxt;
      pub_v_r <= pub_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_r <= in_sample;
    end
    pub_r <= pub_nxt;
  end

  assign pub_valid = pub_v_r;
  assign pub       = pub_r;

endmodule

[rtl/adr_duty.sv]
// Duty computation from the input-voltage sum and the result register.
// Depends on adr_pkg for cfg_t, pub_t and duty_calc.
module adr_duty (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pub_valid,
  input  adr_pkg::pub_t               pub,
  output logic                        pub_take,
  input  adr_pkg::cfg_t               cfg,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_finished_slot,
  output logic [adr_pkg::SUM_W-1:0]   out_channel_sum,
  output logic [adr_pkg::CHAN_W-1:0]  out_next_channel,
  output logic [adr_pkg::SUM_W-1:0]   out_power_duty,
  output logic [adr_pkg::SUM_W-1:0]   out_led_duty
);

  logic                       out_v_r, out_v_nxt;
  logic                       slot_r;
  logic [adr_pkg::SUM_W-1:0]  sum_r;
  logic [adr_pkg::CHAN_W-1:0] chan_r;
  logic [adr_pkg::SUM_W-1:0]  pwr_r, pwr_nxt;
  logic [adr_pkg::SUM_W-1:0]  led_r, led_nxt;
  logic                       load;

  assign pub_take  = ~out_v_r | out_ready;
  assign load      = pub_take & pub_valid;
  assign out_v_nxt = pub_take ? pub_valid : out_v_r;

  assign pwr_nxt = adr_pkg::duty_calc(pub.volt, cfg.voltage_low_limit,
                                      cfg.voltage_high_limit,
                                      cfg.power_duty_full, cfg.power_slope);
  assign led_nxt = adr_pkg::duty_calc(pub.volt, cfg.voltage_low_limit,
                                      cfg.voltage_high_limit,
                                      cfg.led_duty_full, cfg.led_slope);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= pub.finished_slot;
      sum_r  <= pub.channel_sum;
      chan_r <= pub.next_channel;
      pwr_r  <= pwr_nxt;
      led_r  <= led_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_finished_slot = slot_r;
  assign out_channel_sum   = sum_r;
  assign out_next_channel  = chan_r;
  assign out_power_duty    = pwr_r;
  assign out_led_duty      = led_r;

endmodule

[rtl/adc_average_duty_regulator.sv]
// Top level of the averaging converter front end with duty regulation.
// Depends on adr_pkg, adr_if, adr_regs, adr_accum and adr_duty.
//
// Usage:
// The sample channel (in_bus) takes one 10-bit conversion result per
// transaction. Samples are summed for the current table slot; after
// accumulate_count samples the sum is published, the slot advances
// round-robin, and one transaction appears on the result channel
// (out_bus) carrying the finished slot, its sum, the converter channel to
// select next, and the power and LED duties derived from slot 0's sum.
// Samples that do not finish a slot produce no result transaction.
// The APB port writes and reads the eight configuration registers at
// byte addresses 4*i; pready is always high. Write registers only while
// the block is idle.
// The finishing sample passes through the input register, then the publish
// register, then the result register, before out_bus.valid rises.
// The block takes one sample per cycle while out_bus is not stalled; the
// pipeline has three register stages, each with its own valid bit.
// Reset (rst_n low, synchronous) clears the running and slot-0 sums, the
// tally, the slot and every valid bit, and restores the register defaults.
// When the receiver stalls, the result register holds its transaction; the
// stages behind it keep filling until they too are occupied, and only then
// does in_bus.ready drop.
module adc_average_duty_regulator (
  input  logic                        clk,
  input  logic                        rst_n,
  adr_in_if.sink                      in_bus,
  adr_out_if.source                   out_bus,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [adr_pkg::ADDR_W-1:0]  paddr,
  input  logic [adr_pkg::DATA_W-1:0]  pwdata,
  output logic [adr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  adr_pkg::cfg_t cfg;
  adr_pkg::pub_t pub;
  logic          pub_valid;
  logic          pub_take;

  // Configuration registers behind the APB port.
  adr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register, running sum and slot stepping; emits one publish record
  // per finished slot.
  adr_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_sample (in_bus.sample),
    .in_ready  (in_bus.ready),
    .cfg       (cfg),
    .pub_valid (pub_valid),
    .pub       (pub),
    .pub_take  (pub_take)
  );

  // Duty computation (two 16x8 multiplies) into the result register.
  adr_duty u_duty (
    .clk               (clk),
    .rst_n             (rst_n),
    .pub_valid         (pub_valid),
    .pub               (pub),
    .pub_take          (pub_take),
    .cfg               (cfg),
    .out_valid         (out_bus.valid),
    .out_ready         (out_bus.ready),
    .out_finished_slot (out_bus.finished_slot),
    .out_channel_sum   (out_bus.channel_sum),
    .out_next_channel  (out_bus.next_channel),
    .out_power_duty    (out_bus.power_duty),
    .out_led_duty      (out_bus.led_duty)
  );

endmodule

[rtl/adr_checker.sv]
// Port-level checks for the averaging front end, bound to its top level.
// Depends on adc_average_duty_regulator for the bind target.
module adr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_finished_slot,
  input logic [adr_pkg::SUM_W-1:0]   out_channel_sum,
  input logic                        pready
);

  logic exp_slot_r;

  // Slots finish strictly in turn, starting with slot 0 after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_slot_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      exp_slot_r <= ~exp_slot_r;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |-> (out_finished_slot == exp_slot_r))
    else $error("slots finished out of round-robin order");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn while stalled");

  a_hold_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_channel_sum))
    else $error("result sum changed while stalled");

endmodule

bind adc_average_duty_regulator adr_checker u_adr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_finished_slot (out_bus.finished_slot),
  .out_channel_sum   (out_bus.channel_sum),
  .pready            (pready)
);
